### rtl/ljm_pkg.sv
// Shared types and constants for the Lennard-Jones pair coefficient mixer.
`timescale 1ns / 1ps
package ljm_pkg;

  localparam int RSTAR_W  = 21;   // combined radius, 2^-16 angstrom
  localparam int R6_W     = 42;   // R*^6, 2^-16 units
  localparam int RAD_W    = 56;   // sqrt radicand wa*wb*2^16
  localparam int ROOT_W   = 28;   // floor sqrt of the radicand
  localparam int X_W      = 38;   // dividend s*1000 + 2092
  localparam int Q_W      = 26;   // eps in 2^-24 kcal/mol
  localparam int COEF_W   = 63;

  localparam logic [3:0]  RADIUS_SCALE = 4'd10;
  localparam logic [9:0]  KJ_SCALE     = 10'd1000;
  localparam logic [11:0] KJ_BIAS      = 12'd2092;
  // 4184 = 8 * 523: drop three bits, then multiply by ceil(2^45 / 523)
  localparam int          KJ_PRE_SHIFT   = 3;
  localparam logic [35:0] KJ_RECIP       = 36'd67274134014;
  localparam int          KJ_RECIP_SHIFT = 45;

  typedef struct packed {
    logic [15:0]        table_index;
    logic               index_error;
    logic [RSTAR_W-1:0] rstar;
    logic [R6_W-1:0]    r6;
  } side_t;

endpackage

### rtl/ljm_rpow.sv
// Radius power chain: R*^2, R*^3 and R*^6 in three rounded stages.
`timescale 1ns / 1ps
module ljm_rpow (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_vld,
  input  ljm_pkg::side_t              in_side,
  input  logic [ljm_pkg::RAD_W-1:0]   in_rad,
  output logic                        out_vld,
  output ljm_pkg::side_t              out_side,
  output logic [ljm_pkg::RAD_W-1:0]   out_rad
);

  logic                      v1, v2;
  ljm_pkg::side_t            side1, side2;
  ljm_pkg::side_t            out_side_next;
  logic [ljm_pkg::RAD_W-1:0] rad1, rad2;
  logic [24:0]               r2;
  logic [28:0]               r3;
  logic [41:0]               sq2;
  logic [45:0]               p3;
  logic [57:0]               p6;

  assign sq2 = 42'(in_side.rstar) * 42'(in_side.rstar) + 42'h8000;
  assign p3  = 46'(r2) * 46'(side1.rstar) + 46'h8000;
  assign p6  = 58'(r3) * 58'(r3) + 58'h8000;

  always_comb begin
    out_side_next    = side2;
    out_side_next.r6 = p6[57:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
      v2 <= v1;
      out_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1 <= in_side;
      rad1 <= in_rad;
      r2 <= sq2[40:16];
      side2 <= side1;
      rad2 <= rad1;
      r3 <= p3[44:16];
      out_side <= out_side_next;
      out_rad <= rad2;
    end
  end

endmodule

### rtl/ljm_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module ljm_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_vld,
  input  ljm_pkg::side_t               in_side,
  input  logic [ljm_pkg::RAD_W-1:0]    in_rad,
  output logic                         out_vld,
  output ljm_pkg::side_t               out_side,
  output logic [ljm_pkg::ROOT_W-1:0]   out_root
);

  localparam int N = ljm_pkg::ROOT_W;

  logic                      vs   [0:N];
  ljm_pkg::side_t            ss   [0:N];
  logic [ljm_pkg::RAD_W-1:0] rads [0:N];
  logic [N:0]                rems [0:N];
  logic [N-1:0]              roots[0:N];

  assign vs[0]    = in_vld;
  assign ss[0]    = in_side;
  assign rads[0]  = in_rad;
  assign rems[0]  = '0;
  assign roots[0] = '0;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int J = N - 1 - k;
    logic [N+2:0] rem_sh;
    logic [N+2:0] trial;
    logic         take;

    assign rem_sh = {rems[k][N:0], rads[k][2*J+1 -: 2]};
    assign trial  = {1'b0, roots[k], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[k+1] <= 1'b0;
      end else if (adv) begin
        vs[k+1] <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ss[k+1] <= ss[k];
        rads[k+1] <= rads[k];
        if (take) begin
          rems[k+1] <= (N+1)'(rem_sh - trial);
          roots[k+1] <= {roots[k][N-2:0], 1'b1};
        end else begin
          rems[k+1] <= rem_sh[N:0];
          roots[k+1] <= {roots[k][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vs[N];
  assign out_side = ss[N];
  assign out_root = roots[N];

endmodule

### rtl/ljm_cdiv.sv
// Scale by 1000/4184 with rounding: scale stage, then a pipelined reciprocal multiply.
`timescale 1ns / 1ps
module ljm_cdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_vld,
  input  ljm_pkg::side_t              in_side,
  input  logic [ljm_pkg::ROOT_W-1:0]  in_root,
  output logic                        out_vld,
  output ljm_pkg::side_t              out_side,
  output logic [ljm_pkg::Q_W-1:0]     out_eps
);

  localparam int XW = ljm_pkg::X_W;
  localparam int YW = XW - ljm_pkg::KJ_PRE_SHIFT;

  logic           v1, v2;
  ljm_pkg::side_t s1, s2;
  logic [XW-1:0]  x1;
  logic [YW-1:0]  y;
  logic [35:0]    pll, plh;
  logic [34:0]    phl, phh;
  logic [70:0]    prod;

  assign y    = x1[XW-1:ljm_pkg::KJ_PRE_SHIFT];
  assign prod = 71'(pll) + (71'(plh) << 18) + (71'(phl) << 18) + (71'(phh) << 36);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
      v2 <= v1;
      out_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= in_side;
      x1 <= XW'(in_root) * XW'(ljm_pkg::KJ_SCALE) + XW'(ljm_pkg::KJ_BIAS);
      // split the reciprocal product into four narrow partial products
      s2 <= s1;
      pll <= 36'(y[17:0]) * 36'(ljm_pkg::KJ_RECIP[17:0]);
      plh <= 36'(y[17:0]) * 36'(ljm_pkg::KJ_RECIP[35:18]);
      phl <= 35'(y[YW-1:18]) * 35'(ljm_pkg::KJ_RECIP[17:0]);
      phh <= 35'(y[YW-1:18]) * 35'(ljm_pkg::KJ_RECIP[35:18]);
      out_side <= s2;
      out_eps <= prod[ljm_pkg::KJ_RECIP_SHIFT +: ljm_pkg::Q_W];
    end
  end

endmodule

### rtl/ljm_coef.sv
// Coefficient stages: eps*R^6, rounding, second product and saturation.
`timescale 1ns / 1ps
module ljm_coef (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_vld,
  input  ljm_pkg::side_t              in_side,
  input  logic [ljm_pkg::Q_W-1:0]     in_eps,
  output logic                        out_vld,
  output ljm_pkg::side_t              out_side,
  output logic [ljm_pkg::COEF_W-1:0]  a_val,
  output logic [ljm_pkg::COEF_W-1:0]  c_val,
  output logic                        sat
);

  logic           v1, v2, v3, v4, v5;
  ljm_pkg::side_t s1, s2, s3, s4, s5;
  logic [46:0]    pl, ph;
  logic [67:0]    p1;
  logic [37:0]    c3, c4, c5;
  logic [44:0]    t3;
  logic [43:0]    pp00;
  logic [43:0]    pp01;
  logic [42:0]    pp10;
  logic [42:0]    pp11;
  logic [87:0]    pfull;
  logic [68:0]    p1r31, p1r24;
  logic [87:0]    psum;
  logic [64:0]    a_rnd;

  assign p1r31 = 69'(p1) + 69'(1) * 69'h40000000;
  assign p1r24 = 69'(p1) + 69'h800000;
  assign psum  = pfull + 88'h800000;
  assign a_rnd = psum[87:24] == 64'h0 ? 65'h0 : 65'(psum[87:24]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_vld <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // split R^6 so each product stays narrow
      s1 <= in_side;
      pl <= 47'(in_eps) * 47'(in_side.r6[20:0]);
      ph <= 47'(in_eps) * 47'(in_side.r6[41:21]);
      s2 <= s1;
      p1 <= 68'(ph) * 68'h200000 + 68'(pl);
      s3 <= s2;
      c3 <= p1r31[68:31];
      t3 <= p1r24[68:24];
      s4 <= s3;
      c4 <= c3;
      pp00 <= 44'(t3[22:0]) * 44'(s3.r6[20:0]);
      pp01 <= 44'(t3[22:0]) * 44'(s3.r6[41:21]);
      pp10 <= 43'(t3[44:23]) * 43'(s3.r6[20:0]);
      pp11 <= 43'(t3[44:23]) * 43'(s3.r6[41:21]);
      s5 <= s4;
      c5 <= c4;
      pfull <= 88'(pp00) + (88'(pp01) << 21) + (88'(pp10) << 23) + (88'(pp11) << 44);
      out_side <= s5;
      c_val <= 63'(c5);
      if (a_rnd[64:63] != 2'b00) begin
        a_val <= {63{1'b1}};
        sat <= 1'b1;
      end else begin
        a_val <= a_rnd[62:0];
        sat <= 1'b0;
      end
    end
  end

endmodule

### rtl/lj_pair_coefficient_mixer.sv
// Top level of the Lennard-Jones pair coefficient mixer.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall) carries one atom type pair: the two
//   type indices, two radii (2^-16 nm) and two well depths (2^-16 kJ/mol).
//   Output channel (out_valid / out_stall) returns one result per pair:
//   table index, combined radius R*, A = eps*R^12, C = 2*eps*R^6 (2^-8
//   units), a saturation flag and an index error flag.
//   cfg_write / cfg_data load type_count (row length of the pair table);
//   write it only while no pair is in flight.
// Timing:
//   The pipeline has one input stage, three radius power stages,
//   28 square root stages (one root bit each), three divide stages (scale,
//   reciprocal partial products, sum) and six coefficient stages.
//   One pair per cycle unless stalled; every stage advances together.
// Reset (rst, synchronous): clears all valid bits and sets type_count to 1.
// Stall: when a result waits under out_stall, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is lost or repeated.
module lj_pair_coefficient_mixer #(
  parameter int MAX_TYPES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  type_a,
  input  logic [7:0]  type_b,
  input  logic [15:0] radius_a,
  input  logic [19:0] well_a,
  input  logic [15:0] radius_b,
  input  logic [19:0] well_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] table_index,
  output logic [20:0] rstar,
  output logic [62:0] a_coef,
  output logic [62:0] c_coef,
  output logic        saturated,
  output logic        index_error
);

  localparam logic [12:0] MAXT = 13'(MAX_TYPES);

  logic [8:0]  type_count;
  logic        adv;
  logic [12:0] cnt_wide;
  logic [8:0]  cnt;
  logic        ierr;
  logic [16:0] idx_full;
  logic [16:0] rsum;

  logic                      v0, v_rp, v_sq, v_dv;
  ljm_pkg::side_t            side0, side_in, side_rp, side_sq, side_dv, side_out;
  logic [ljm_pkg::RAD_W-1:0] rad0, rad_rp;
  logic [ljm_pkg::ROOT_W-1:0] root;
  logic [ljm_pkg::Q_W-1:0]   eps;

  // hold every stage while a finished result is refused
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      type_count <= 9'd1;
    end else if (cfg_write) begin
      type_count <= cfg_data;
    end
  end

  // clip the row length to the table size
  assign cnt_wide = ({4'b0, type_count} > MAXT) ? MAXT : {4'b0, type_count};
  assign cnt      = cnt_wide[8:0];
  assign ierr     = ({1'b0, type_a} >= cnt) || ({1'b0, type_b} >= cnt);
  assign idx_full = 17'(type_a) * 17'(cnt) + 17'(type_b);
  assign rsum     = 17'(radius_a) + 17'(radius_b);

  always_comb begin
    side_in             = '0;
    side_in.table_index = ierr ? 16'h0 : idx_full[15:0];
    side_in.index_error = ierr;
    side_in.rstar       = 21'(rsum) * 21'(ljm_pkg::RADIUS_SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side0 <= side_in;
      rad0 <= {40'(well_a) * 40'(well_b), 16'h0};
    end
  end

  ljm_rpow u_rpow (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(v0), .in_side(side0), .in_rad(rad0),
    .out_vld(v_rp), .out_side(side_rp), .out_rad(rad_rp)
  );

  ljm_sqrt u_sqrt (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(v_rp), .in_side(side_rp), .in_rad(rad_rp),
    .out_vld(v_sq), .out_side(side_sq), .out_root(root)
  );

  ljm_cdiv u_cdiv (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(v_sq), .in_side(side_sq), .in_root(root),
    .out_vld(v_dv), .out_side(side_dv), .out_eps(eps)
  );

  ljm_coef u_coef (
    .clk(clk), .rst(rst), .adv(adv),
    .in_vld(v_dv), .in_side(side_dv), .in_eps(eps),
    .out_vld(out_valid), .out_side(side_out),
    .a_val(a_coef), .c_val(c_coef), .sat(saturated)
  );

  assign table_index = side_out.table_index;
  assign index_error = side_out.index_error;
  assign rstar       = side_out.rstar;

`ifndef SYNTHESIS
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a refused result");

  a_err_zero_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && index_error) |-> (table_index == 16'h0))
    else $error("index error with nonzero table index");

  a_rstar_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rstar <= 21'd1310700))
    else $error("combined radius out of range");

  a_c_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (c_coef[62:38] == 25'h0))
    else $error("attractive coefficient wider than its product allows");
`endif

endmodule
